// ===== rtl/histogram_equalizer_core_defines.svh =====
// Assertion macros for the histogram equaliser core.
// Used by the checker only; needs nothing else.
`ifndef HISTOGRAM_EQUALIZER_CORE_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_CORE_DEFINES_SVH

// concurrent check, switched off while reset is low
`define HEQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication form of the above
`define HEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  `HEQ_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

// ===== rtl/heq_pkg.sv =====
// Package for the histogram equaliser: widths, defaults and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package heq_pkg;
  localparam int unsigned MAX_SAMPLES_DEF   = 4096;
  localparam int unsigned LEVEL_BITS_DEF    = 8;
  localparam int unsigned FRACTION_BITS_DEF = 4;
  localparam int unsigned INTENSITY_W       = 12;
  localparam int unsigned VALUE_W           = 16;
  localparam int unsigned FS_W              = 8;
  localparam int unsigned OUT_FRAC          = 8;
  localparam logic [FS_W-1:0] FS_RESET      = 8'd255;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  typedef struct packed {
    logic accept;   // word taken this cycle
    logic l_rd;     // histogram read for a load
    logic l_wr;     // histogram increment
    logic c_rd;     // cumulative sweep read
    logic c_wr;     // cumulative sweep write
    logic e_rd;     // level buffer read
    logic e_hr;     // histogram read for an emit
    logic e_mul;    // product, divider load
    logic e_div;    // one quotient bit
    logic e_out;    // result register load
  } heq_cmd_t;

  typedef struct packed {
    logic load_full;
    logic cnt_zero;
    logic emitting;
    logic rp_done;
    logic sweep_last;
    logic div_last;
    logic out_free;
  } heq_sts_t;
endpackage

// ===== rtl/histogram_equalizer_core.sv =====
// Channel  | handshake           | payload
// in       | in_valid/in_ready   | operation, intensity
// out      | out_valid/out_ready | equalized_value, last_of_set, degenerate_set,
//          |                     | samples_dropped
// cfg      | cfg_we              | cfg_output_full_scale
// Load: histogram read, then increment. A dropped load takes no further steps.
// Emit: buffer read, histogram read, multiply, 16 divider steps, result
// load; the first emit of a set adds the cumulative sweep, a read and a write
// per histogram level. Rate is set by the one-bit-per-cycle divider.
// Reset is asynchronous; no clearing pass, histogram entries carry valid bits.
// A full result register holds the sequencer in its last step until taken.
`timescale 1ns / 1ps
module histogram_equalizer_core #(
  parameter int unsigned MAX_SAMPLES   = heq_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned LEVEL_BITS    = heq_pkg::LEVEL_BITS_DEF,
  parameter int unsigned FRACTION_BITS = heq_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [heq_pkg::INTENSITY_W-1:0] intensity_i,
  input  logic                            cfg_we_i,
  input  logic [heq_pkg::FS_W-1:0]        cfg_output_full_scale_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [heq_pkg::VALUE_W-1:0]     equalized_value_o,
  output logic                            last_of_set_o,
  output logic                            degenerate_set_o,
  output logic                            samples_dropped_o
);
  heq_pkg::heq_cmd_t cmd;
  heq_pkg::heq_sts_t sts;

  heq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  heq_datapath #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .LEVEL_BITS    (LEVEL_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .operation_i             (operation_i),
    .intensity_i             (intensity_i),
    .cfg_we_i                (cfg_we_i),
    .cfg_output_full_scale_i (cfg_output_full_scale_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .equalized_value_o       (equalized_value_o),
    .last_of_set_o           (last_of_set_o),
    .degenerate_set_o        (degenerate_set_o),
    .samples_dropped_o       (samples_dropped_o)
  );
endmodule

// ===== rtl/heq_ctrl.sv =====
// Sequencer for the histogram equaliser.
// Depends on heq_pkg for the command and status structs.
`timescale 1ns / 1ps
module heq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             operation_i,
  input  heq_pkg::heq_sts_t sts_i,
  output logic             in_ready_o,
  output heq_pkg::heq_cmd_t cmd_o
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LRD  = 4'd1;
  localparam logic [3:0] S_LWR  = 4'd2;
  localparam logic [3:0] S_CRD  = 4'd3;
  localparam logic [3:0] S_CWR  = 4'd4;
  localparam logic [3:0] S_ERD  = 4'd5;
  localparam logic [3:0] S_EHR  = 4'd6;
  localparam logic [3:0] S_EMUL = 4'd7;
  localparam logic [3:0] S_EDIV = 4'd8;
  localparam logic [3:0] S_EOUT = 4'd9;

  logic [3:0] state_q, state_d;
  logic       acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = acc;
    state_d      = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (operation_i == heq_pkg::OP_LOAD) begin
            state_d = sts_i.load_full ? S_IDLE : S_LRD;
          end else if (sts_i.cnt_zero) begin
            state_d = S_IDLE;
          end else if (!sts_i.emitting) begin
            state_d = S_CRD;
          end else if (sts_i.rp_done) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_ERD;
          end
        end
      end
      S_LRD: begin
        cmd_o.l_rd = 1'b1;
        state_d    = S_LWR;
      end
      S_LWR: begin
        cmd_o.l_wr = 1'b1;
        state_d    = S_IDLE;
      end
      S_CRD: begin
        cmd_o.c_rd = 1'b1;
        state_d    = S_CWR;
      end
      S_CWR: begin
        cmd_o.c_wr = 1'b1;
        state_d    = sts_i.sweep_last ? S_ERD : S_CRD;
      end
      S_ERD: begin
        cmd_o.e_rd = 1'b1;
        state_d    = S_EHR;
      end
      S_EHR: begin
        cmd_o.e_hr = 1'b1;
        state_d    = S_EMUL;
      end
      S_EMUL: begin
        cmd_o.e_mul = 1'b1;
        state_d     = S_EDIV;
      end
      S_EDIV: begin
        cmd_o.e_div = 1'b1;
        state_d     = sts_i.div_last ? S_EOUT : S_EDIV;
      end
      S_EOUT: begin
        if (sts_i.out_free) begin
          cmd_o.e_out = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== rtl/heq_datapath.sv =====
// Datapath of the histogram equaliser: level buffer, histogram memory,
// cumulative sweep, multiplier and restoring divider. Depends on heq_pkg.
`timescale 1ns / 1ps
module heq_datapath #(
  parameter int unsigned MAX_SAMPLES   = heq_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned LEVEL_BITS    = heq_pkg::LEVEL_BITS_DEF,
  parameter int unsigned FRACTION_BITS = heq_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  heq_pkg::heq_cmd_t               cmd_i,
  output heq_pkg::heq_sts_t               sts_o,
  input  logic                            operation_i,
  input  logic [heq_pkg::INTENSITY_W-1:0] intensity_i,
  input  logic                            cfg_we_i,
  input  logic [heq_pkg::FS_W-1:0]        cfg_output_full_scale_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [heq_pkg::VALUE_W-1:0]     equalized_value_o,
  output logic                            last_of_set_o,
  output logic                            degenerate_set_o,
  output logic                            samples_dropped_o
);
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES);
  localparam int unsigned HD     = 1 << LEVEL_BITS;
  localparam int unsigned HALF   = (1 << FRACTION_BITS) >> 1;
  localparam int unsigned RAW_W  = heq_pkg::INTENSITY_W;
  localparam int unsigned FS_W   = heq_pkg::FS_W;
  localparam int unsigned VW     = heq_pkg::VALUE_W;
  localparam int unsigned OF     = heq_pkg::OUT_FRAC;
  localparam int unsigned PW     = CNT_W + FS_W;
  localparam int unsigned DC_W   = $clog2(VW);
  localparam logic [LEVEL_BITS-1:0] LV_TOP = {LEVEL_BITS{1'b1}};

  logic [FS_W-1:0]       fs_q;
  logic [CNT_W-1:0]      cnt_q, rp_q, min_q, run_q;
  logic                  emit_q, ovf_q, found_q;
  logic [LEVEL_BITS-1:0] lvl_q, sweep_q;
  logic [HD-1:0]         hv_q;

  // memories
  logic [CNT_W-1:0]      hist_mem [HD];
  logic [LEVEL_BITS-1:0] lbuf_mem [MAX_SAMPLES];
  logic [CNT_W-1:0]      hist_rd_q;
  logic                  hv_rd_q;
  logic [LEVEL_BITS-1:0] lb_rd_q;
  logic [LEVEL_BITS-1:0] hist_raddr;
  logic                  hist_we;
  logic [LEVEL_BITS-1:0] hist_waddr;
  logic [CNT_W-1:0]      hist_wdata;
  logic                  lb_we;
  logic [CNT_W-1:0]      hist_val;

  // divider
  logic [CNT_W-1:0]      rem_q;
  logic [VW-1:0]         nq_q;
  logic [DC_W-1:0]       dcnt_q;
  logic [CNT_W-1:0]      span;
  logic [CNT_W:0]        rem2;
  logic                  ge;
  logic [CNT_W-1:0]      diff;
  logic [PW-1:0]         prod;

  // input level
  logic [RAW_W:0]        lsum, lshift;
  logic [31:0]           lshift32;
  logic [LEVEL_BITS-1:0] in_level;

  logic [CNT_W-1:0]      run_d;
  logic                  out_valid_q;

  assign lsum     = {1'b0, intensity_i} + (RAW_W + 1)'(HALF);
  assign lshift   = lsum >> FRACTION_BITS;
  assign lshift32 = 32'(lshift);
  assign in_level = (lshift32 > 32'(LV_TOP)) ? LV_TOP : lshift32[LEVEL_BITS-1:0];

  assign hist_val = hv_rd_q ? hist_rd_q : '0;
  assign run_d    = run_q + hist_val;

  always_comb begin
    hist_raddr = lvl_q;
    if (cmd_i.c_rd) hist_raddr = sweep_q;
    if (cmd_i.e_hr) hist_raddr = lb_rd_q;
  end

  assign hist_we    = cmd_i.l_wr || cmd_i.c_wr;
  assign hist_waddr = cmd_i.c_wr ? sweep_q : lvl_q;
  assign hist_wdata = cmd_i.c_wr ? run_d : hist_val + CNT_W'(1);

  assign sts_o.load_full  = !emit_q && (cnt_q == CNT_W'(MAX_SAMPLES));
  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.emitting   = emit_q;
  assign sts_o.rp_done    = (rp_q >= cnt_q);
  assign sts_o.sweep_last = (sweep_q == LV_TOP);
  assign sts_o.div_last   = (dcnt_q == DC_W'(VW - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign lb_we = cmd_i.accept && (operation_i == heq_pkg::OP_LOAD) && !sts_o.load_full;

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rd_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk_i) begin
    // a load after emitting starts at entry zero
    if (lb_we) lbuf_mem[emit_q ? '0 : cnt_q[IDX_W-1:0]] <= in_level;
    if (cmd_i.e_rd) lb_rd_q <= lbuf_mem[rp_q[IDX_W-1:0]];
  end

  // multiply then restoring divide; quotient always fits VW bits
  assign diff = hist_val - min_q;
  assign prod = PW'(diff) * PW'(fs_q);
  assign span = cnt_q - min_q;
  assign rem2 = {rem_q, nq_q[VW-1]};
  assign ge   = rem2 >= {1'b0, span};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) lvl_q <= in_level;
    if (cmd_i.e_mul) begin
      rem_q <= prod[PW-1:OF];
      nq_q  <= {prod[OF-1:0], {(VW - OF){1'b0}}};
    end else if (cmd_i.e_div) begin
      rem_q <= ge ? CNT_W'(rem2 - {1'b0, span}) : CNT_W'(rem2);
      nq_q  <= {nq_q[VW-2:0], ge};
    end
    if (cmd_i.e_out) begin
      equalized_value_o <= (span == '0) ? '0 : nq_q;
      last_of_set_o     <= (rp_q + CNT_W'(1)) == cnt_q;
      degenerate_set_o  <= (span == '0);
      samples_dropped_o <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q        <= heq_pkg::FS_RESET;
      cnt_q       <= '0;
      rp_q        <= '0;
      min_q       <= '0;
      run_q       <= '0;
      emit_q      <= 1'b0;
      ovf_q       <= 1'b0;
      found_q     <= 1'b0;
      sweep_q     <= '0;
      hv_q        <= '0;
      hv_rd_q     <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) fs_q <= cfg_output_full_scale_i;
      hv_rd_q <= hv_q[hist_raddr];
      if (cmd_i.accept && operation_i == heq_pkg::OP_LOAD) begin
        if (emit_q) begin
          hv_q   <= '0;
          rp_q   <= '0;
          min_q  <= '0;
          emit_q <= 1'b0;
          ovf_q  <= 1'b0;
          cnt_q  <= CNT_W'(1);
        end else if (sts_o.load_full) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.accept && operation_i == heq_pkg::OP_EMIT && !emit_q) begin
        sweep_q <= '0;
        run_q   <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.l_wr) hv_q[lvl_q] <= 1'b1;
      if (cmd_i.c_wr) begin
        hv_q[sweep_q] <= 1'b1;
        run_q         <= run_d;
        sweep_q       <= sweep_q + LEVEL_BITS'(1);
        if (!found_q && run_d != '0) begin
          min_q   <= run_d;
          found_q <= 1'b1;
        end
        if (sts_o.sweep_last) begin
          emit_q <= 1'b1;
          rp_q   <= '0;
        end
      end
      if (cmd_i.e_mul) dcnt_q <= '0;
      if (cmd_i.e_div) dcnt_q <= dcnt_q + DC_W'(1);
      if (cmd_i.e_out) begin
        rp_q        <= rp_q + CNT_W'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

// ===== rtl/heq_checker.sv =====
// Port-level checks for the histogram equaliser core, bound to the top.
// Depends on histogram_equalizer_core_defines.svh and heq_pkg.
`timescale 1ns / 1ps
`include "histogram_equalizer_core_defines.svh"
module heq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [heq_pkg::VALUE_W-1:0]     equalized_value_o,
  input logic                            degenerate_set_o
);
  `HEQ_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, ##1 out_valid_o, "out word dropped while stalled")
  `HEQ_ASSERT_IMP(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, ##1 $stable(equalized_value_o), "out word changed while stalled")
  `HEQ_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, out_valid_o && degenerate_set_o, equalized_value_o == '0, "degenerate word not zero")
  `HEQ_ASSERT_IMP(a_out_busy, clk_i, rst_ni, $rose(out_valid_o), $past(!in_ready_o), "result appeared while idle")
endmodule

bind histogram_equalizer_core heq_checker u_heq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .equalized_value_o (equalized_value_o),
  .degenerate_set_o  (degenerate_set_o)
);
